>>> src/srtc_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the swizzled texel reorder and convert block
// no dependencies

package srtc_pkg;

   localparam int MAX_DIM_LOG2    = 12;
   localparam int DIM_LIM         = 1 << MAX_DIM_LOG2;
   localparam int PALETTE_ENTRIES = 256;

   localparam int CNT_W       = 24;
   localparam int DIM_W       = 13;
   localparam int K_W         = 4;
   localparam int TOT_W       = 2 * DIM_W;
   localparam int QUEUE_DEPTH = 4;
   localparam int CSR_IDX_W   = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_ORDER  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TEXEL_FORMAT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TEX_WIDTH    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TEX_HEIGHT   = 3'd3;

   localparam logic OP_TEXEL   = 1'b0;
   localparam logic OP_PALETTE = 1'b1;

   localparam logic ORDER_LINEAR   = 1'b0;
   localparam logic ORDER_SWIZZLED = 1'b1;

   localparam logic [2:0] FMT_U8      = 3'd0;
   localparam logic [2:0] FMT_BGR     = 3'd1;
   localparam logic [2:0] FMT_RGB     = 3'd2;
   localparam logic [2:0] FMT_ARGB    = 3'd3;
   localparam logic [2:0] FMT_P8_RGB  = 3'd4;
   localparam logic [2:0] FMT_P8_ARGB = 3'd5;

   typedef struct packed {
      logic        operation;
      logic [7:0]  palette_slot;
      logic [31:0] raw_bytes;
   } req_type;

   typedef struct packed {
      logic [23:0] dest_index;
      logic [31:0] out_bytes;
      logic [2:0]  byte_count;
      logic        bad_dimensions;
      logic        last_texel;
   } rsp_type;

   // one classified item between front and back
   typedef struct packed {
      logic             operation;
      logic [7:0]       palette_slot;
      logic [31:0]      raw_bytes;
      logic [2:0]       texel_format;
      logic [CNT_W-1:0] lin_pos;
      logic             need_div;
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic             bad;
      logic             last;
   } qent_type;

endpackage

>>> src/srtc_front.sv
`timescale 1ns / 1ps
// front end: configuration registers, texel counter, morton decode and classification
// depends on srtc_pkg

module srtc_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [srtc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [srtc_pkg::DIM_W-1:0]           csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  srtc_pkg::req_type                    req_data,
   output logic                                 q_push,
   output srtc_pkg::qent_type                   q_data,
   input  logic                                 q_full
);

   localparam int CNT_W = srtc_pkg::CNT_W;
   localparam int DIM_W = srtc_pkg::DIM_W;
   localparam int K_W   = srtc_pkg::K_W;
   localparam int TOT_W = srtc_pkg::TOT_W;
   localparam int HALF  = CNT_W / 2;

   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
      logic [DIM_W-1:0] r;
      if (d == '0) begin
         r = DIM_W'(16);
      end else if (int'(d) > srtc_pkg::DIM_LIM) begin
         r = DIM_W'(srtc_pkg::DIM_LIM);
      end else begin
         r = d;
      end
      return r;
   endfunction

   logic                 order_ff, order_in;
   logic [2:0]           fmt_ff, fmt_in;
   logic [DIM_W-1:0]     width_ff, width_in;
   logic [DIM_W-1:0]     height_ff, height_in;
   logic [TOT_W-1:0]     total_ff, total_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 fr_valid_ff, fr_valid_in;
   srtc_pkg::req_type    fr_ff;

   logic [DIM_W-1:0]     w_eff, h_eff, mn, mn_m1;
   logic [K_W-1:0]       k;
   logic [K_W:0]         k2;
   logic [CNT_W-1:0]     low_mask, ev_bits, od_bits, xd, yd, j_swz;
   logic [HALF-1:0]      ev, od;
   logic                 h_lt_w, swz, w_pow2, h_pow2, last;
   logic                 accept;

   // configuration
   always_comb begin
      order_in  = order_ff;
      fmt_in    = fmt_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         unique case (csr_index)
            srtc_pkg::CSR_PIXEL_ORDER:  order_in  = csr_wdata[0];
            srtc_pkg::CSR_TEXEL_FORMAT: fmt_in    = csr_wdata[2:0];
            srtc_pkg::CSR_TEX_WIDTH:    width_in  = csr_wdata;
            srtc_pkg::CSR_TEX_HEIGHT:   height_in = csr_wdata;
            default: ;
         endcase
      end
      total_in = TOT_W'(eff_dim(width_in)) * TOT_W'(eff_dim(height_in));
   end

   // geometry of the current texel
   always_comb begin
      w_eff  = eff_dim(width_ff);
      h_eff  = eff_dim(height_ff);
      h_lt_w = h_eff < w_eff;
      mn     = h_lt_w ? h_eff : w_eff;
      mn_m1  = mn - DIM_W'(1);
      k      = '0;
      for (int b = 0; b < DIM_W; b++) begin
         if (mn[b]) begin
            k = K_W'(b);
         end
      end
      k2 = {k, 1'b0};
      for (int b = 0; b < CNT_W; b++) begin
         low_mask[b] = b < int'(k2);
      end
      for (int n = 0; n < HALF; n++) begin
         ev[n] = cnt_ff[2 * n];
         od[n] = cnt_ff[2 * n + 1];
      end
      ev_bits = CNT_W'(ev);
      od_bits = CNT_W'(od);
      xd      = ev_bits & CNT_W'(mn_m1);
      yd      = od_bits & CNT_W'(mn_m1);
      if (h_lt_w) begin
         j_swz = (cnt_ff & ~low_mask) | (yd << k) | xd;
      end else begin
         j_swz = (cnt_ff & ~low_mask) | (xd << k) | yd;
      end
      swz    = order_ff == srtc_pkg::ORDER_SWIZZLED;
      w_pow2 = (w_eff & (w_eff - DIM_W'(1))) == '0;
      h_pow2 = (h_eff & (h_eff - DIM_W'(1))) == '0;
      last   = TOT_W'(cnt_ff) >= (total_ff - TOT_W'(1));
   end

   // handshake and queue entry
   always_comb begin
      q_push      = fr_valid_ff && !q_full;
      req_ready   = !fr_valid_ff || !q_full;
      accept      = req_valid && req_ready;
      fr_valid_in = accept || (fr_valid_ff && !q_push);

      q_data.operation    = fr_ff.operation;
      q_data.palette_slot = fr_ff.palette_slot;
      q_data.raw_bytes    = fr_ff.raw_bytes;
      q_data.texel_format = fmt_ff;
      q_data.lin_pos      = swz ? j_swz : cnt_ff;
      q_data.need_div     = swz && h_lt_w;
      q_data.width        = w_eff;
      q_data.height       = h_eff;
      q_data.bad          = swz && !(w_pow2 && h_pow2);
      q_data.last         = last;

      cnt_in = cnt_ff;
      if (q_push && fr_ff.operation == srtc_pkg::OP_TEXEL) begin
         cnt_in = last ? '0 : cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff    <= srtc_pkg::ORDER_LINEAR;
         fmt_ff      <= srtc_pkg::FMT_U8;
         width_ff    <= DIM_W'(16);
         height_ff   <= DIM_W'(16);
         total_ff    <= TOT_W'(256);
         cnt_ff      <= '0;
         fr_valid_ff <= 1'b0;
      end else begin
         order_ff    <= order_in;
         fmt_ff      <= fmt_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         total_ff    <= total_in;
         cnt_ff      <= cnt_in;
         fr_valid_ff <= fr_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fr_ff <= req_data;
      end
   end

   // counter wraps to zero after the final texel
   a_last_wrap: assert property (@(posedge clock) disable iff (reset)
      (q_push && fr_ff.operation == srtc_pkg::OP_TEXEL && last) |=> (cnt_ff == '0))
      else $error("texel counter did not wrap after last texel");

endmodule

>>> src/srtc_queue.sv
`timescale 1ns / 1ps
// short fifo of classified items between front and back
// depends on srtc_pkg

module srtc_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  srtc_pkg::qent_type   push_data,
   output logic                 full,
   input  logic                 pop,
   output srtc_pkg::qent_type   pop_data,
   output logic                 empty
);

   localparam int DEPTH = srtc_pkg::QUEUE_DEPTH;
   localparam int AW    = $clog2(DEPTH);

   srtc_pkg::qent_type entry_ff [DEPTH];
   logic [AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [AW:0]        count_ff, count_in;

   always_comb begin
      full      = count_ff == (AW + 1)'(DEPTH);
      empty     = count_ff == '0;
      pop_data  = entry_ff[rd_ptr_ff];
      wr_ptr_in = push ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      count_in  = count_ff + (AW + 1)'(push) - (AW + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("pop from empty queue");

endmodule

>>> src/srtc_back.sv
`timescale 1ns / 1ps
// back end: palette store, byte conversion, pipelined divider and index multiply
// depends on srtc_pkg

module srtc_back #(
   parameter int PALETTE_ENTRIES = srtc_pkg::PALETTE_ENTRIES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  srtc_pkg::qent_type   q_data,
   input  logic                 q_empty,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output srtc_pkg::rsp_type    rsp_data
);

   localparam int CNT_W  = srtc_pkg::CNT_W;
   localparam int DIM_W  = srtc_pkg::DIM_W;
   localparam int TOT_W  = srtc_pkg::TOT_W;
   localparam int PAL_AW = $clog2(PALETTE_ENTRIES);

   typedef struct packed {
      logic             need_div;
      logic [CNT_W-1:0] lin_pos;
      logic [CNT_W-1:0] quo;
      logic [DIM_W-1:0] rem;
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic [31:0]      bytes;
      logic [2:0]       count;
      logic             bad;
      logic             last;
   } dstg_type;

   typedef struct packed {
      logic             need_div;
      logic [CNT_W-1:0] lin_pos;
      logic [CNT_W-1:0] quo;
      logic [TOT_W-1:0] prod;
      logic [31:0]      bytes;
      logic [2:0]       count;
      logic             bad;
      logic             last;
   } mstg_type;

   logic                 adv;
   logic                 wr_ok, rd_ok;
   logic [31:0]          pal_mem [PALETTE_ENTRIES];
   logic [31:0]          pal_rd_ff;
   logic                 rd_ok_ff;
   srtc_pkg::qent_type   a_ff;
   logic                 a_valid_ff;
   logic [31:0]          color, a_bytes;
   logic [2:0]           a_count;
   dstg_type             a_out;
   dstg_type             d_ff [CNT_W+1];
   dstg_type             d_in [CNT_W];
   logic                 dv_ff [CNT_W+1];
   logic [DIM_W:0]       rem_sh [CNT_W];
   mstg_type             m_ff;
   logic                 m_valid_ff;
   logic                 rsp_valid_ff;
   srtc_pkg::rsp_type    rsp_ff, rsp_in;

   always_comb begin
      adv   = !rsp_valid_ff || rsp_ready;
      q_pop = adv && !q_empty;
      wr_ok = {1'b0, q_data.palette_slot} < 9'(PALETTE_ENTRIES);
      rd_ok = {1'b0, q_data.raw_bytes[7:0]} < 9'(PALETTE_ENTRIES);
   end

   // palette store
   always_ff @(posedge clock) begin
      if (q_pop && q_data.operation == srtc_pkg::OP_PALETTE && wr_ok) begin
         pal_mem[q_data.palette_slot[PAL_AW-1:0]] <= q_data.raw_bytes;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pal_rd_ff <= pal_mem[q_data.raw_bytes[PAL_AW-1:0]];
         rd_ok_ff  <= rd_ok;
         a_ff      <= q_data;
      end
   end

   // byte conversion
   always_comb begin
      color = rd_ok_ff ? pal_rd_ff : '0;
      unique case (a_ff.texel_format)
         srtc_pkg::FMT_BGR: begin
            a_bytes = {8'h00, a_ff.raw_bytes[23:0]};
            a_count = 3'd3;
         end
         srtc_pkg::FMT_RGB: begin
            a_bytes = {8'h00, a_ff.raw_bytes[7:0], a_ff.raw_bytes[15:8],
                       a_ff.raw_bytes[23:16]};
            a_count = 3'd3;
         end
         srtc_pkg::FMT_ARGB: begin
            a_bytes = {a_ff.raw_bytes[31:24], a_ff.raw_bytes[7:0], a_ff.raw_bytes[15:8],
                       a_ff.raw_bytes[23:16]};
            a_count = 3'd4;
         end
         srtc_pkg::FMT_P8_RGB: begin
            a_bytes = {8'h00, color[7:0], color[15:8], color[23:16]};
            a_count = 3'd3;
         end
         srtc_pkg::FMT_P8_ARGB: begin
            a_bytes = {color[31:24], color[7:0], color[15:8], color[23:16]};
            a_count = 3'd4;
         end
         default: begin
            a_bytes = {24'h000000, a_ff.raw_bytes[7:0]};
            a_count = 3'd1;
         end
      endcase
      a_out.need_div = a_ff.need_div;
      a_out.lin_pos  = a_ff.lin_pos;
      a_out.quo      = '0;
      a_out.rem      = '0;
      a_out.width    = a_ff.width;
      a_out.height   = a_ff.height;
      a_out.bytes    = a_bytes;
      a_out.count    = a_count;
      a_out.bad      = a_ff.bad;
      a_out.last     = a_ff.last;
   end

   // restoring divider, one quotient bit per stage
   always_comb begin
      for (int s = 0; s < CNT_W; s++) begin
         d_in[s]   = d_ff[s];
         rem_sh[s] = {d_ff[s].rem, d_ff[s].lin_pos[CNT_W-1-s]};
         if (rem_sh[s] >= {1'b0, d_ff[s].height}) begin
            d_in[s].rem              = DIM_W'(rem_sh[s] - {1'b0, d_ff[s].height});
            d_in[s].quo[CNT_W-1-s]   = 1'b1;
         end else begin
            d_in[s].rem = rem_sh[s][DIM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff[0] <= a_out;
         for (int s = 0; s < CNT_W; s++) begin
            d_ff[s+1] <= d_in[s];
         end
         m_ff.need_div <= d_ff[CNT_W].need_div;
         m_ff.lin_pos  <= d_ff[CNT_W].lin_pos;
         m_ff.quo      <= d_ff[CNT_W].quo;
         m_ff.prod     <= TOT_W'(d_ff[CNT_W].width) * TOT_W'(d_ff[CNT_W].rem);
         m_ff.bytes    <= d_ff[CNT_W].bytes;
         m_ff.count    <= d_ff[CNT_W].count;
         m_ff.bad      <= d_ff[CNT_W].bad;
         m_ff.last     <= d_ff[CNT_W].last;
         rsp_ff        <= rsp_in;
      end
   end

   // destination index: column-major split when swizzled and height is below width
   always_comb begin
      rsp_in.dest_index     = m_ff.need_div ? m_ff.quo + m_ff.prod[CNT_W-1:0]
                                            : m_ff.lin_pos;
      rsp_in.out_bytes      = m_ff.bytes;
      rsp_in.byte_count     = m_ff.count;
      rsp_in.bad_dimensions = m_ff.bad;
      rsp_in.last_texel     = m_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         m_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s <= CNT_W; s++) begin
            dv_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         a_valid_ff <= q_pop && q_data.operation == srtc_pkg::OP_TEXEL;
         dv_ff[0]   <= a_valid_ff;
         for (int s = 0; s < CNT_W; s++) begin
            dv_ff[s+1] <= dv_ff[s];
         end
         m_valid_ff   <= dv_ff[CNT_W];
         rsp_valid_ff <= m_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_byte_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.byte_count == 3'd1 || rsp_data.byte_count == 3'd3 ||
                     rsp_data.byte_count == 3'd4))
      else $error("illegal byte count on result");

endmodule

>>> src/swizzled_texel_reorder_convert.sv
`timescale 1ns / 1ps
// top level of the swizzled texel reorder and convert block
// depends on srtc_pkg, srtc_front, srtc_queue, srtc_back
//
//   port group  direction  handshake           payload
//   req_        in         req_valid/ready     srtc_pkg::req_type
//   rsp_        out        rsp_valid/ready     srtc_pkg::rsp_type
//   csr_        in         csr_we              csr_index, csr_wdata
//
// one item per cycle unless rsp_ready stalls; a palette write uses a slot, gives no result
// req to rsp path: front reg, queue, palette read, 24-stage divider, multiply, rsp reg
// reset clears counter and valids, sets default config; palette undefined until written
// a stalled rsp freezes the back pipeline; the 4-entry queue fills and req_ready drops

module swizzled_texel_reorder_convert #(
   parameter int PALETTE_ENTRIES = srtc_pkg::PALETTE_ENTRIES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [srtc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [srtc_pkg::DIM_W-1:0]       csr_wdata,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  srtc_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output srtc_pkg::rsp_type                rsp_data
);

   logic                q_push, q_full, q_pop, q_empty;
   srtc_pkg::qent_type  q_wr_data, q_rd_data;

   srtc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_push    (q_push),
      .q_data    (q_wr_data),
      .q_full    (q_full)
   );

   srtc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wr_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rd_data),
      .empty     (q_empty)
   );

   srtc_back #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_data    (q_rd_data),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
